### rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, command codes and saturation helpers of the fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic [31:0] MAX32 = 32'h7fff_ffff;
  localparam logic [31:0] MIN32 = 32'h8000_0000;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_t;

  // one word in flight
  typedef struct packed {
    cmd_e        cmd;
    logic        neg;
    logic        a_pos;
    logic        a_neg;
    logic        div_zero;
    logic        div_ovf;
    logic [31:0] den;
    logic [32:0] rem;
    logic [31:0] lo;
    logic [31:0] q;
    logic [63:0] prod;
    logic [31:0] res;
    logic        cmp;
    logic [1:0]  st;
  } pipe_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] res;
    logic        cmp;
    logic [1:0]  st;
  } res_t;

  // apply sign to a magnitude, saturate to 32 bits
  function automatic sat_t signed_sat(input logic neg, input logic [63:0] mag);
    sat_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.sat = 1'b1;
        r.val = MIN32;
      end else begin
        r.val = 32'(-mag[31:0]);
      end
    end else begin
      if (mag > 64'h7fff_ffff) begin
        r.sat = 1'b1;
        r.val = MAX32;
      end else begin
        r.val = mag[31:0];
      end
    end
    return r;
  endfunction

  // clamp a 33-bit signed sum
  function automatic sat_t clamp33(input logic [32:0] s);
    sat_t r;
    r.sat = s[32] ^ s[31];
    if (r.sat) begin
      r.val = s[32] ? MIN32 : MAX32;
    end else begin
      r.val = s[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/fpa_in_if.sv
// ----------------------------------------------------------------------------
// fpa_in_if
// Command channel of the fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         command;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source(output valid, command, operand_a, operand_b, input ready);
  modport sink(input valid, command, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

### rtl/fpa_out_if.sv
// ----------------------------------------------------------------------------
// fpa_out_if
// Result channel of the fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               compare_true;
  logic [1:0]         status;

  modport source(output valid, result_value, compare_true, status, input ready);
  modport sink(input valid, result_value, compare_true, status, output ready);
endinterface

`default_nettype wire

### rtl/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Pipelined signed fixed-point ALU with saturation and rounded mul/div.
// ----------------------------------------------------------------------------
// throughput: one word per cycle while the skid entry is empty; the divider
// retires one quotient bit per stage (32 stages) and the multiplier has a stage
// of its own; a two-entry output (register plus skid) keeps input open while one
// result waits and closes it once the skid entry is full
// reset clears all valid bits at once; no stored state beyond pipeline and output
`default_nettype none

module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = 8
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  fpa_in_if.sink       in_i,
  fpa_out_if.source    out_o
);

  localparam int NUM_W = 32 + FRAC_BITS;
  localparam int QBITS = 32;
  localparam int NS    = 3 + QBITS;
  localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

  fpa_pkg::pipe_t pipe_q [NS];
  fpa_pkg::pipe_t pipe_d [NS];
  logic           valid_q [NS];
  logic           en;

  fpa_pkg::res_t  out_q, sk_q, fin;
  logic           out_valid_q, sk_valid_q;

  assign en         = !sk_valid_q;
  assign in_i.ready = en;

  // stage 0: magnitudes, simple ops, divider setup
  always_comb begin
    logic signed [31:0] a, b;
    logic [31:0]        ma, mb;
    logic [NUM_W-1:0]   num;
    logic [32:0]        m33;
    logic [31:0]        mt;
    fpa_pkg::sat_t      s;
    fpa_pkg::pipe_t     p;
    a   = in_i.operand_a;
    b   = in_i.operand_b;
    ma  = a[31] ? 32'(-a) : 32'(a);
    mb  = b[31] ? 32'(-b) : 32'(b);
    num = {ma, {FRAC_BITS{1'b0}}};
    m33 = 33'({1'b0, ma} + 33'(HALF));
    mt  = 32'(m33 >> FRAC_BITS);
    s   = '0;
    p   = '0;
    p.cmd      = fpa_pkg::cmd_e'(in_i.command);
    p.neg      = a[31] ^ b[31];
    p.a_pos    = !a[31] && (a != 0);
    p.a_neg    = a[31];
    p.div_zero = (b == 0);
    p.div_ovf  = {{(32 - FRAC_BITS){1'b0}}, num[NUM_W-1:32]} >= mb;
    p.den      = mb;
    p.rem      = {{(33 - FRAC_BITS){1'b0}}, num[NUM_W-1:32]};
    p.lo       = num[31:0];
    p.st       = fpa_pkg::ST_OK;
    case (p.cmd)
      fpa_pkg::CMD_ADD: s = fpa_pkg::clamp33(33'({a[31], a} + {b[31], b}));
      fpa_pkg::CMD_SUB: s = fpa_pkg::clamp33(33'({a[31], a} - {b[31], b}));
      fpa_pkg::CMD_INC: s = fpa_pkg::clamp33(33'({a[31], a} + 33'd1));
      fpa_pkg::CMD_DEC: s = fpa_pkg::clamp33(33'({a[31], a} - 33'd1));
      fpa_pkg::CMD_FROM_INT: s = fpa_pkg::signed_sat(a[31], 64'(num));
      fpa_pkg::CMD_TO_INT: s.val = a[31] ? 32'(-mt) : mt;
      fpa_pkg::CMD_MIN: s.val = (a <= b) ? a : b;
      fpa_pkg::CMD_MAX: s.val = (a >= b) ? a : b;
      fpa_pkg::CMD_GT: p.cmp = a > b;
      fpa_pkg::CMD_LT: p.cmp = a < b;
      fpa_pkg::CMD_GE: p.cmp = a >= b;
      fpa_pkg::CMD_LE: p.cmp = a <= b;
      fpa_pkg::CMD_EQ: p.cmp = a == b;
      fpa_pkg::CMD_NE: p.cmp = a != b;
      default: s = '0;
    endcase
    p.res = s.val;
    if (s.sat) p.st = fpa_pkg::ST_SAT;
    pipe_d[0] = p;
  end

  // stage 1: magnitude product
  always_comb begin
    pipe_d[1]      = pipe_q[0];
    pipe_d[1].prod = 64'(pipe_q[0].den) *
                     64'(32'({pipe_q[0].rem[31:0], pipe_q[0].lo} >> FRAC_BITS));
  end

  // stage 2: round and saturate the product
  always_comb begin
    logic [63:0]   m;
    fpa_pkg::sat_t s;
    m = (pipe_q[1].prod + HALF) >> FRAC_BITS;
    s = fpa_pkg::signed_sat(pipe_q[1].neg, m);
    pipe_d[2] = pipe_q[1];
    if (pipe_q[1].cmd == fpa_pkg::CMD_MUL) begin
      pipe_d[2].res = s.val;
      pipe_d[2].st  = s.sat ? fpa_pkg::ST_SAT : fpa_pkg::ST_OK;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 3; k < NS; k++) begin : g_div
    always_comb begin
      logic [32:0] sh;
      sh = {pipe_q[k-1].rem[31:0], pipe_q[k-1].lo[31]};
      pipe_d[k]    = pipe_q[k-1];
      pipe_d[k].lo = {pipe_q[k-1].lo[30:0], 1'b0};
      if (sh >= {1'b0, pipe_q[k-1].den}) begin
        pipe_d[k].rem = sh - {1'b0, pipe_q[k-1].den};
        pipe_d[k].q   = {pipe_q[k-1].q[30:0], 1'b1};
      end else begin
        pipe_d[k].rem = sh;
        pipe_d[k].q   = {pipe_q[k-1].q[30:0], 1'b0};
      end
    end
  end

  // final select, divide rounding
  always_comb begin
    fpa_pkg::pipe_t p;
    logic [32:0]    m;
    fpa_pkg::sat_t  s;
    p = pipe_q[NS-1];
    m = {1'b0, p.q} + 33'({p.rem[31:0], 1'b0} >= {1'b0, p.den});
    s = fpa_pkg::signed_sat(p.neg, 64'(m));
    fin.cmd = p.cmd;
    fin.res = p.res;
    fin.cmp = p.cmp;
    fin.st  = p.st;
    if (p.cmd == fpa_pkg::CMD_DIV) begin
      if (p.div_zero) begin
        fin.st  = fpa_pkg::ST_DIVZ;
        fin.res = p.a_pos ? fpa_pkg::MAX32 : (p.a_neg ? fpa_pkg::MIN32 : '0);
      end else if (p.div_ovf) begin
        fin.st  = fpa_pkg::ST_SAT;
        fin.res = p.neg ? fpa_pkg::MIN32 : fpa_pkg::MAX32;
      end else begin
        fin.st  = s.sat ? fpa_pkg::ST_SAT : fpa_pkg::ST_OK;
        fin.res = s.val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) valid_q[i] <= 1'b0;
    end else if (en) begin
      valid_q[0] <= in_i.valid;
      for (int i = 1; i < NS; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NS; i++) pipe_q[i] <= pipe_d[i];
    end
  end

  // output register plus skid entry
  logic stalled;
  assign stalled = out_valid_q && !out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else if (!stalled) begin
      out_valid_q <= sk_valid_q || valid_q[NS-1];
      sk_valid_q  <= 1'b0;
    end else if (en && valid_q[NS-1]) begin
      sk_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stalled) begin
      out_q <= sk_valid_q ? sk_q : fin;
    end else if (en && valid_q[NS-1]) begin
      sk_q <= fin;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_q.res;
  assign out_o.compare_true = out_q.cmp;
  assign out_o.status       = out_q.st;

  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.cmp |-> out_q.res == '0 && out_q.st == fpa_pkg::ST_OK)
    else $error("compare result with nonzero value or status");

  a_divz_only_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.st == fpa_pkg::ST_DIVZ |-> out_q.cmd == fpa_pkg::CMD_DIV)
    else $error("divide-by-zero status on a non-divide word");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> valid_q[0])
    else $error("accepted word missing from first stage");

  a_skid_only_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> out_valid_q)
    else $error("skid entry held without a waiting output");

endmodule

`default_nettype wire

### sim/tb_fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_q24_8_alu
// Drives command words into the fixed-point ALU with random idling on both
// sides and compares every result word against a directed expected value or an exact integer predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fixed_point_q24_8_alu;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam int N_RAND = 830;
  localparam longint MAXV = 64'sd2147483647;
  localparam longint MINV = -64'sd2147483648;

  typedef struct packed {
    logic [31:0] val;
    logic        cmp;
    logic [1:0]  st;
  } alu_res_t;

  typedef struct {
    fpa_pkg::cmd_e cmd;
    logic [31:0]   a;
    logic [31:0]   b;
    logic          has_exp;
    alu_res_t      exp;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  fpa_in_if  cmd_ch();
  fpa_out_if res_ch();

  fixed_point_q24_8_alu #(.FRAC_BITS(FRAC)) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch.sink),
    .out_o (res_ch.source)
  );

  alu_res_t pending_q[$];
  int       mismatches = 0;
  bit       sending_done = 1'b0;
  bit       quiet = 1'b0;
  bit       hold_long = 1'b0;

  function automatic longint sat_mag(input bit neg, input longint unsigned mag,
                                     inout logic [1:0] st);
    if (neg) begin
      if (mag > 64'd2147483648) begin
        st = fpa_pkg::ST_SAT;
        return MINV;
      end
      return -longint'(mag);
    end
    if (mag > 64'd2147483647) begin
      st = fpa_pkg::ST_SAT;
      return MAXV;
    end
    return longint'(mag);
  endfunction

  function automatic longint clamp(input longint v, inout logic [1:0] st);
    if (v > MAXV) begin
      st = fpa_pkg::ST_SAT;
      return MAXV;
    end
    if (v < MINV) begin
      st = fpa_pkg::ST_SAT;
      return MINV;
    end
    return v;
  endfunction

  function automatic longint unsigned absval(input longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic alu_res_t alu_predict(input fpa_pkg::cmd_e cmd,
                                           input logic [31:0] ra,
                                           input logic [31:0] rb);
    longint a, b, r;
    longint unsigned m, num, den;
    logic [1:0] st;
    logic cmp;
    alu_res_t res;
    a = longint'($signed(ra));
    b = longint'($signed(rb));
    r = 0;
    st = fpa_pkg::ST_OK;
    cmp = 1'b0;
    case (cmd)
      fpa_pkg::CMD_ADD: r = clamp(a + b, st);
      fpa_pkg::CMD_SUB: r = clamp(a - b, st);
      fpa_pkg::CMD_MUL: begin
        m = (absval(a) * absval(b) + (64'd1 << (FRAC - 1))) >> FRAC;
        r = sat_mag((a < 0) != (b < 0), m, st);
      end
      fpa_pkg::CMD_DIV: begin
        if (b == 0) begin
          st = fpa_pkg::ST_DIVZ;
          r = a > 0 ? MAXV : (a < 0 ? MINV : 0);
        end else begin
          num = absval(a) << FRAC;
          den = absval(b);
          m = (2 * num + den) / (2 * den);
          r = sat_mag((a < 0) != (b < 0), m, st);
        end
      end
      fpa_pkg::CMD_GT: cmp = a > b;
      fpa_pkg::CMD_LT: cmp = a < b;
      fpa_pkg::CMD_GE: cmp = a >= b;
      fpa_pkg::CMD_LE: cmp = a <= b;
      fpa_pkg::CMD_EQ: cmp = a == b;
      fpa_pkg::CMD_NE: cmp = a != b;
      fpa_pkg::CMD_MIN: r = a <= b ? a : b;
      fpa_pkg::CMD_MAX: r = a >= b ? a : b;
      fpa_pkg::CMD_INC: r = clamp(a + 1, st);
      fpa_pkg::CMD_DEC: r = clamp(a - 1, st);
      fpa_pkg::CMD_FROM_INT: r = sat_mag(a < 0, absval(a) << FRAC, st);
      default: begin
        m = (absval(a) + (64'd1 << (FRAC - 1))) >> FRAC;
        r = a < 0 ? -longint'(m) : longint'(m);
      end
    endcase
    res.val = r[31:0];
    res.cmp = cmp;
    res.st = st;
    return res;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return fpa_pkg::MAX32 - $urandom_range(0, 3);
      1: return fpa_pkg::MIN32 + $urandom_range(0, 3);
      2: return 32'(int'($urandom_range(0, 1024)) - 512);
      3: return 32'(int'($urandom_range(0, 20)) - 10) << FRAC;
      4: return 32'($urandom_range(0, 32'hffff)) ^ {32{$urandom_range(0, 1) == 1}};
      5: return {24'($signed(-$urandom_range(0, 1))), 8'h80};
      default: return $urandom;
    endcase
  endfunction

  vec_t vecs[$];

  function automatic vec_t mk(input fpa_pkg::cmd_e c, input logic [31:0] a,
                              input logic [31:0] b, input bit has,
                              input logic [31:0] v, input logic cmp,
                              input logic [1:0] st);
    vec_t t;
    t.cmd = c;
    t.a = a;
    t.b = b;
    t.has_exp = has;
    t.exp = '{val: v, cmp: cmp, st: st};
    return t;
  endfunction

  initial begin
    vecs.push_back(mk(fpa_pkg::CMD_ADD, fpa_pkg::MAX32, 32'd1, 1'b1,
                      fpa_pkg::MAX32, 1'b0, fpa_pkg::ST_SAT));
    vecs.push_back(mk(fpa_pkg::CMD_ADD, fpa_pkg::MIN32, fpa_pkg::MIN32, 1'b1,
                      fpa_pkg::MIN32, 1'b0, fpa_pkg::ST_SAT));
    vecs.push_back(mk(fpa_pkg::CMD_SUB, fpa_pkg::MIN32, 32'd1, 1'b1,
                      fpa_pkg::MIN32, 1'b0, fpa_pkg::ST_SAT));
    vecs.push_back(mk(fpa_pkg::CMD_SUB, fpa_pkg::MAX32, fpa_pkg::MIN32, 1'b1,
                      fpa_pkg::MAX32, 1'b0, fpa_pkg::ST_SAT));
    vecs.push_back(mk(fpa_pkg::CMD_MUL, fpa_pkg::MAX32, fpa_pkg::MAX32, 1'b1,
                      fpa_pkg::MAX32, 1'b0, fpa_pkg::ST_SAT));
    vecs.push_back(mk(fpa_pkg::CMD_MUL, fpa_pkg::MIN32, fpa_pkg::MAX32, 1'b1,
                      fpa_pkg::MIN32, 1'b0, fpa_pkg::ST_SAT));
    vecs.push_back(mk(fpa_pkg::CMD_MUL, 32'hffff_ff80, 32'd1, 1'b0,
                      32'd0, 1'b0, fpa_pkg::ST_OK));
    vecs.push_back(mk(fpa_pkg::CMD_DIV, 32'd100, 32'd0, 1'b1,
                      fpa_pkg::MAX32, 1'b0, fpa_pkg::ST_DIVZ));
    vecs.push_back(mk(fpa_pkg::CMD_DIV, 32'hffff_ff00, 32'd0, 1'b1,
                      fpa_pkg::MIN32, 1'b0, fpa_pkg::ST_DIVZ));
    vecs.push_back(mk(fpa_pkg::CMD_DIV, 32'd0, 32'd0, 1'b1,
                      32'd0, 1'b0, fpa_pkg::ST_DIVZ));
    vecs.push_back(mk(fpa_pkg::CMD_DIV, fpa_pkg::MIN32, 32'hffff_ffff, 1'b1,
                      fpa_pkg::MAX32, 1'b0, fpa_pkg::ST_SAT));
    vecs.push_back(mk(fpa_pkg::CMD_DIV, 32'd1, 32'd3, 1'b0,
                      32'd0, 1'b0, fpa_pkg::ST_OK));
    vecs.push_back(mk(fpa_pkg::CMD_GT, fpa_pkg::MAX32, fpa_pkg::MIN32, 1'b1,
                      32'd0, 1'b1, fpa_pkg::ST_OK));
    vecs.push_back(mk(fpa_pkg::CMD_LT, fpa_pkg::MAX32, fpa_pkg::MIN32, 1'b1,
                      32'd0, 1'b0, fpa_pkg::ST_OK));
    vecs.push_back(mk(fpa_pkg::CMD_GE, 32'd5, 32'd5, 1'b1,
                      32'd0, 1'b1, fpa_pkg::ST_OK));
    vecs.push_back(mk(fpa_pkg::CMD_LE, fpa_pkg::MIN32, fpa_pkg::MIN32, 1'b1,
                      32'd0, 1'b1, fpa_pkg::ST_OK));
    vecs.push_back(mk(fpa_pkg::CMD_EQ, 32'd7, 32'd7, 1'b1,
                      32'd0, 1'b1, fpa_pkg::ST_OK));
    vecs.push_back(mk(fpa_pkg::CMD_NE, 32'd7, 32'd7, 1'b1,
                      32'd0, 1'b0, fpa_pkg::ST_OK));
    vecs.push_back(mk(fpa_pkg::CMD_MIN, fpa_pkg::MAX32, fpa_pkg::MIN32, 1'b1,
                      fpa_pkg::MIN32, 1'b0, fpa_pkg::ST_OK));
    vecs.push_back(mk(fpa_pkg::CMD_MAX, fpa_pkg::MAX32, fpa_pkg::MIN32, 1'b1,
                      fpa_pkg::MAX32, 1'b0, fpa_pkg::ST_OK));
    vecs.push_back(mk(fpa_pkg::CMD_INC, fpa_pkg::MAX32, 32'd0, 1'b1,
                      fpa_pkg::MAX32, 1'b0, fpa_pkg::ST_SAT));
    vecs.push_back(mk(fpa_pkg::CMD_DEC, fpa_pkg::MIN32, 32'd0, 1'b1,
                      fpa_pkg::MIN32, 1'b0, fpa_pkg::ST_SAT));
    vecs.push_back(mk(fpa_pkg::CMD_FROM_INT, 32'h0080_0000, 32'd0, 1'b1,
                      fpa_pkg::MAX32, 1'b0, fpa_pkg::ST_SAT));
    vecs.push_back(mk(fpa_pkg::CMD_FROM_INT, 32'hff80_0000, 32'd0, 1'b1,
                      fpa_pkg::MIN32, 1'b0, fpa_pkg::ST_OK));
    vecs.push_back(mk(fpa_pkg::CMD_TO_INT, fpa_pkg::MIN32, fpa_pkg::MAX32, 1'b1,
                      32'hff80_0000, 1'b0, fpa_pkg::ST_OK));
  end

  // sender
  initial begin
    vec_t t;
    int idle;
    cmd_ch.valid <= 1'b0;
    cmd_ch.command <= '0;
    cmd_ch.operand_a <= '0;
    cmd_ch.operand_b <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < vecs.size() + N_RAND; i++) begin
      if (i < vecs.size()) begin
        t = vecs[i];
      end else begin
        t.cmd = fpa_pkg::cmd_e'(4'($urandom_range(0, 15)));
        t.a = pick_operand();
        t.b = ($urandom_range(0, 15) == 0) ? 32'd0 : pick_operand();
        t.has_exp = 1'b0;
      end
      if (i > vecs.size() + N_RAND - 120) quiet = 1'b1;
      if (i == vecs.size() + 100) hold_long = 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) begin
        idle = $urandom_range(1, 4);
        cmd_ch.valid <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      cmd_ch.valid <= 1'b1;
      cmd_ch.command <= t.cmd;
      cmd_ch.operand_a <= t.a;
      cmd_ch.operand_b <= t.b;
      pending_q.push_back(t.has_exp ? t.exp : alu_predict(t.cmd, t.a, t.b));
      @(posedge clk_i);
      while (!cmd_ch.ready) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // receiver
  initial begin
    int idle;
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (120) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        idle = $urandom_range(1, 4);
        res_ch.ready <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // checker
  always @(posedge clk_i) begin
    alu_res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", res_ch.result_value);
      end else begin
        want = pending_q.pop_front();
        if (res_ch.result_value !== want.val || res_ch.compare_true !== want.cmp ||
            res_ch.status !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp val=%h cmp=%b st=%0d got val=%h cmp=%b st=%0d",
                     want.val, want.cmp, want.st, res_ch.result_value,
                     res_ch.compare_true, res_ch.status);
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** fixed_point_q24_8_alu: PASSED **");
    end else begin
      $display("** fixed_point_q24_8_alu: FAILED **");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("** fixed_point_q24_8_alu: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
